// File: rtl/core/scan_code_to_ascii_translator_macros.svh
// Assertion macros shared by the scan code translator RTL.
`ifndef SCAN_CODE_TO_ASCII_TRANSLATOR_MACROS_SVH
`define SCAN_CODE_TO_ASCII_TRANSLATOR_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define SC2A_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scan code translator: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define SC2A_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scan code translator: same-cycle check failed");

`endif

// File: rtl/core/sc2a_pkg.sv
// Scan code constants and translation tables for the scan code translator.
package sc2a_pkg;

    localparam int unsigned CODE_W  = 8;
    localparam int unsigned TABLE_N = 64;

    typedef logic [CODE_W-1:0] byte_t;

    // Make codes.
    localparam byte_t SC_ESCAPE      = 8'h01;
    localparam byte_t SC_LCTRL_MAKE  = 8'h1d;
    localparam byte_t SC_LSHIFT_MAKE = 8'h2a;
    localparam byte_t SC_RSHIFT_MAKE = 8'h36;
    localparam byte_t SC_CAPS_MAKE   = 8'h3a;
    localparam byte_t SC_RCTRL_MAKE  = 8'h5a;
    localparam byte_t SC_UP_MAKE     = 8'h48;
    localparam byte_t SC_LEFT_MAKE   = 8'h4b;
    localparam byte_t SC_RIGHT_MAKE  = 8'h4d;
    localparam byte_t SC_DOWN_MAKE   = 8'h50;

    // Break codes.
    localparam byte_t SC_LCTRL_BREAK  = 8'h9d;
    localparam byte_t SC_LSHIFT_BREAK = 8'haa;
    localparam byte_t SC_RSHIFT_BREAK = 8'hb6;
    localparam byte_t SC_CAPS_BREAK   = 8'hba;
    localparam byte_t SC_RCTRL_BREAK  = 8'hda;

    // Output characters.
    localparam byte_t CH_UP        = 8'h86;
    localparam byte_t CH_LEFT      = 8'h83;
    localparam byte_t CH_RIGHT     = 8'h84;
    localparam byte_t CH_DOWN      = 8'h85;
    localparam byte_t CH_BACKSPACE = 8'h08;
    localparam byte_t CH_LOWER_H   = 8'h68;
    localparam byte_t CH_SPACE     = 8'h20;
    localparam byte_t CH_NONE      = 8'h00;

    localparam byte_t PLAIN_KEYS [0:TABLE_N-1] = '{
        8'h20, 8'h20, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0d, 8'h20, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
        8'h27, 8'h60, 8'h20, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6e, 8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h20, 8'h20,
        8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20
    };

    localparam byte_t UPPER_KEYS [0:TABLE_N-1] = '{
        8'h20, 8'h20, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e,
        8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0d, 8'h20, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
        8'h22, 8'h7e, 8'h20, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h20, 8'h20,
        8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20
    };

    // Codes with bit 6 set have no table entry and read as a space; other codes index the table by their low six bits.
    function automatic byte_t plain_key(input byte_t code);
        return code[6] ? CH_SPACE : PLAIN_KEYS[code[5:0]];
    endfunction

    function automatic byte_t upper_key(input byte_t code);
        return code[6] ? CH_SPACE : UPPER_KEYS[code[5:0]];
    endfunction

endpackage

// File: rtl/core/scan_code_to_ascii_translator.sv
// Scan code set 1 to ASCII translator with modifier tracking.
//
// The input channel (s_valid, s_ready, s_scan_code) takes one raw scan code
// word per cycle while s_ready is high. The result channel (m_valid,
// m_ready, m_character, m_power_off) gives at most one word for each scan
// code: break codes, modifier makes and the caps lock make give none.
// A scan code is held in an input register, translated against the modifier
// flags, and written to the result register when that register is empty or
// its result is being taken, and the result is offered from that register.
// Throughput is one scan code per cycle while the receiver takes each result;
// the single output register sets it. When the receiver stalls with a result
// waiting, the input register still takes one more code, and s_ready then
// drops until the result is taken. The escape make gives character zero with
// m_power_off set. Synchronous reset clears both registers' valid flags and
// all modifier flags, including caps lock.
`include "scan_code_to_ascii_translator_macros.svh"

module scan_code_to_ascii_translator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_scan_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_character,
    output logic       m_power_off
);

    logic                 in_valid_reg;
    sc2a_pkg::byte_t      code_reg;
    logic                 out_valid_reg;
    sc2a_pkg::byte_t      character_reg;
    logic                 power_off_reg;
    logic                 lshift_reg, rshift_reg, lctrl_reg, rctrl_reg, caps_reg;

    logic                 lshift_next, rshift_next, lctrl_next, rctrl_next, caps_next;
    logic                 produce;
    sc2a_pkg::byte_t      character_next;
    logic                 power_off_next;
    logic                 out_free;
    logic                 advance;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    always_comb begin
        lshift_next    = lshift_reg;
        rshift_next    = rshift_reg;
        lctrl_next     = lctrl_reg;
        rctrl_next     = rctrl_reg;
        caps_next      = caps_reg;
        produce        = 1'b0;
        character_next = sc2a_pkg::CH_NONE;
        power_off_next = 1'b0;
        priority if (code_reg[7]) begin
            unique case (code_reg)
                sc2a_pkg::SC_LCTRL_BREAK:  lctrl_next  = 1'b0;
                sc2a_pkg::SC_LSHIFT_BREAK: lshift_next = 1'b0;
                sc2a_pkg::SC_RSHIFT_BREAK: rshift_next = 1'b0;
                sc2a_pkg::SC_CAPS_BREAK:   caps_next   = !caps_reg;
                sc2a_pkg::SC_RCTRL_BREAK:  rctrl_next  = 1'b0;
                default: ;
            endcase
        end else begin
            unique case (code_reg)
                sc2a_pkg::SC_ESCAPE: begin
                    produce        = 1'b1;
                    power_off_next = 1'b1;
                end
                sc2a_pkg::SC_LCTRL_MAKE:  lctrl_next  = 1'b1;
                sc2a_pkg::SC_LSHIFT_MAKE: lshift_next = 1'b1;
                sc2a_pkg::SC_RSHIFT_MAKE: rshift_next = 1'b1;
                sc2a_pkg::SC_CAPS_MAKE:   ;
                sc2a_pkg::SC_RCTRL_MAKE:  rctrl_next  = 1'b1;
                sc2a_pkg::SC_UP_MAKE: begin
                    produce        = 1'b1;
                    character_next = sc2a_pkg::CH_UP;
                end
                sc2a_pkg::SC_LEFT_MAKE: begin
                    produce        = 1'b1;
                    character_next = sc2a_pkg::CH_LEFT;
                end
                sc2a_pkg::SC_RIGHT_MAKE: begin
                    produce        = 1'b1;
                    character_next = sc2a_pkg::CH_RIGHT;
                end
                sc2a_pkg::SC_DOWN_MAKE: begin
                    produce        = 1'b1;
                    character_next = sc2a_pkg::CH_DOWN;
                end
                default: begin
                    produce = 1'b1;
                    priority if ((lctrl_reg || rctrl_reg) &&
                                 sc2a_pkg::plain_key(code_reg) == sc2a_pkg::CH_LOWER_H) begin
                        character_next = sc2a_pkg::CH_BACKSPACE;
                    end else if ((lshift_reg || rshift_reg) != caps_reg) begin
                        character_next = sc2a_pkg::upper_key(code_reg);
                    end else begin
                        character_next = sc2a_pkg::plain_key(code_reg);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lshift_reg    <= 1'b0;
            rshift_reg    <= 1'b0;
            lctrl_reg     <= 1'b0;
            rctrl_reg     <= 1'b0;
            caps_reg      <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= produce;
                lshift_reg    <= lshift_next;
                rshift_reg    <= rshift_next;
                lctrl_reg     <= lctrl_next;
                rctrl_reg     <= rctrl_next;
                caps_reg      <= caps_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            code_reg <= s_scan_code;
        end
        if (advance) begin
            character_reg <= character_next;
            power_off_reg <= power_off_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_character = character_reg;
    assign m_power_off = power_off_reg;

    `SC2A_ASSERT_SAME(a_power_off_zero_char, aclk, aresetn,
        out_valid_reg && power_off_reg, character_reg == sc2a_pkg::CH_NONE)
    `SC2A_ASSERT_NEXT(a_break_no_result, aclk, aresetn,
        advance && code_reg[7], !out_valid_reg)
    `SC2A_ASSERT_NEXT(a_caps_toggles, aclk, aresetn,
        advance && code_reg == sc2a_pkg::SC_CAPS_BREAK, caps_reg != $past(caps_reg))
    `SC2A_ASSERT_NEXT(a_held_code_kept, aclk, aresetn,
        in_valid_reg && !advance, in_valid_reg && $stable(code_reg))

endmodule
